### rtl/dmrs_pkg.sv
package dmrs_pkg;

    // field widths
    localparam int KIND_W     = 1;
    localparam int DOT_ROW_W  = 5;
    localparam int DOT_COL_W  = 7;
    localparam int CHAN_W     = 8;
    localparam int COLOUR_W   = 24;
    localparam int SIZE_W     = 4;
    localparam int GAP_W      = 4;
    localparam int BORDER_W   = 6;
    localparam int PITCH_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // largest register values, used to size the scan counters
    localparam int SIZE_MAX   = 15;
    localparam int GAP_MAX    = 15;
    localparam int BORDER_MAX = 63;

    localparam logic KIND_DOT_WRITE = 1'b0;
    localparam logic KIND_ADVANCE   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT_SIZE    = 3'd0,
        REG_DOT_GAP     = 3'd1,
        REG_ROW_GAP     = 3'd2,
        REG_COL_GAP     = 3'd3,
        REG_BORDER      = 3'd4,
        REG_ON_COLOUR   = 3'd5,
        REG_OFF_COLOUR  = 3'd6,
        REG_BACK_COLOUR = 3'd7
    } cfg_reg_t;

    localparam logic [SIZE_W-1:0]   DOT_SIZE_RST    = 4'd4;
    localparam logic [GAP_W-1:0]    DOT_GAP_RST     = 4'd1;
    localparam logic [GAP_W-1:0]    ROW_GAP_RST     = 4'd3;
    localparam logic [GAP_W-1:0]    COL_GAP_RST     = 4'd3;
    localparam logic [BORDER_W-1:0] BORDER_RST      = 6'd0;
    localparam logic [COLOUR_W-1:0] ON_COLOUR_RST   = 24'h000000;
    localparam logic [COLOUR_W-1:0] OFF_COLOUR_RST  = 24'hffffff;
    localparam logic [COLOUR_W-1:0] BACK_COLOUR_RST = 24'hffffff;

    // where along one axis the scan position sits
    typedef enum logic [1:0] {
        SEG_LEAD,
        SEG_DOTS,
        SEG_CGAP,
        SEG_TAIL
    } seg_t;

    // rebuilding the axis decomposition after a geometry change
    typedef enum logic [1:0] {
        SYNC_IDLE,
        SYNC_CLEAR,
        SYNC_WALK
    } sync_t;

    typedef struct packed {
        logic clear;
        logic step;
    } axis_cmd_t;

    typedef struct packed {
        logic on_dot;
        logic last;
    } axis_stat_t;

endpackage

### rtl/dmrs_req_if.sv
interface dmrs_req_if;
    import dmrs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [DOT_ROW_W-1:0] dot_row;
    logic [DOT_COL_W-1:0] dot_col;
    logic                 dot_value;

    modport source (output valid, kind, dot_row, dot_col, dot_value, input ready);
    modport sink   (input valid, kind, dot_row, dot_col, dot_value, output ready);
endinterface

### rtl/dmrs_pix_if.sv
interface dmrs_pix_if;
    import dmrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              line_end;
    logic              frame_end;

    modport source (output valid, red, green, blue, line_end, frame_end, input ready);
    modport sink   (input valid, red, green, blue, line_end, frame_end, output ready);
endinterface

### rtl/dot_matrix_raster_scanout_unit.sv
// Channel | Dir | Payload                                | Transfer when
// req     | in  | kind, dot_row, dot_col, dot_value      | req.valid & req.ready
// pix     | out | red, green, blue, line_end, frame_end  | pix.valid & pix.ready
// wr_*    | in  | wr_index, wr_data                      | wr_en
//
// One item per cycle while req.ready is high; after its advance transfer a pixel
// passes the dot store read register, then the output register.
// After reset the dot store is cleared one dot per cycle, all CHAR_ROWS*FONT_HEIGHT*
// CHAR_COLS*FONT_WIDTH dots (3200 by default), with req.ready low.
// A geometry register write (indices 0..4) rebuilds the scan decomposition
// (clear state, then walk back to the scan position) with req.ready low.
// A stalled pix output holds; req keeps flowing until both stages are full.
module dot_matrix_raster_scanout_unit #(
    parameter int CHAR_COLS   = 20,
    parameter int CHAR_ROWS   = 4,
    parameter int FONT_WIDTH  = 5,
    parameter int FONT_HEIGHT = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [dmrs_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [dmrs_pkg::CFG_DATA_W-1:0]   wr_data,
    dmrs_req_if.sink                          req,
    dmrs_pix_if.source                        pix
);
    import dmrs_pkg::*;

    localparam int DOT_COLS = CHAR_COLS * FONT_WIDTH;
    localparam int DOT_ROWS = CHAR_ROWS * FONT_HEIGHT;
    localparam int DOT_NUM  = DOT_COLS * DOT_ROWS;
    localparam int ADDR_W   = $clog2(DOT_NUM);
    localparam int X_IDX_W  = $clog2(DOT_COLS);
    localparam int Y_IDX_W  = $clog2(DOT_ROWS);
    localparam int X_EXT_MAX = 2 * BORDER_MAX + (CHAR_COLS - 1) * GAP_MAX
                             + DOT_COLS * (SIZE_MAX + GAP_MAX);
    localparam int Y_EXT_MAX = 2 * BORDER_MAX + (CHAR_ROWS - 1) * GAP_MAX
                             + DOT_ROWS * (SIZE_MAX + GAP_MAX);
    localparam int X_POS_W  = $clog2(X_EXT_MAX + 1);
    localparam int Y_POS_W  = $clog2(Y_EXT_MAX + 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DOT_NUM - 1);

    // configuration
    logic [SIZE_W-1:0]   dot_size_reg;
    logic [GAP_W-1:0]    dot_gap_reg;
    logic [GAP_W-1:0]    row_gap_reg;
    logic [GAP_W-1:0]    col_gap_reg;
    logic [BORDER_W-1:0] border_reg;
    logic [COLOUR_W-1:0] on_colour_reg;
    logic [COLOUR_W-1:0] off_colour_reg;
    logic [COLOUR_W-1:0] back_colour_reg;
    logic [SIZE_W-1:0]   size_eff;
    logic                geo_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_size_reg    <= DOT_SIZE_RST;
            dot_gap_reg     <= DOT_GAP_RST;
            row_gap_reg     <= ROW_GAP_RST;
            col_gap_reg     <= COL_GAP_RST;
            border_reg      <= BORDER_RST;
            on_colour_reg   <= ON_COLOUR_RST;
            off_colour_reg  <= OFF_COLOUR_RST;
            back_colour_reg <= BACK_COLOUR_RST;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_DOT_SIZE:    dot_size_reg    <= wr_data[SIZE_W-1:0];
                REG_DOT_GAP:     dot_gap_reg     <= wr_data[GAP_W-1:0];
                REG_ROW_GAP:     row_gap_reg     <= wr_data[GAP_W-1:0];
                REG_COL_GAP:     col_gap_reg     <= wr_data[GAP_W-1:0];
                REG_BORDER:      border_reg      <= wr_data[BORDER_W-1:0];
                REG_ON_COLOUR:   on_colour_reg   <= wr_data[COLOUR_W-1:0];
                REG_OFF_COLOUR:  off_colour_reg  <= wr_data[COLOUR_W-1:0];
                REG_BACK_COLOUR: back_colour_reg <= wr_data[COLOUR_W-1:0];
                default:         border_reg      <= border_reg;
            endcase
        end
    end

    assign size_eff  = (dot_size_reg == '0) ? SIZE_W'(1) : dot_size_reg;
    assign geo_write = wr_en && (wr_index == REG_DOT_SIZE || wr_index == REG_DOT_GAP
                              || wr_index == REG_ROW_GAP  || wr_index == REG_COL_GAP
                              || wr_index == REG_BORDER);

    // scan axes
    axis_cmd_t            x_cmd, y_cmd;
    axis_stat_t           x_stat, y_stat;
    logic [X_POS_W-1:0]   x_pos;
    logic [Y_POS_W-1:0]   y_pos;
    logic [X_IDX_W-1:0]   x_idx;
    logic [Y_IDX_W-1:0]   y_idx;

    dmrs_axis #(
        .CELLS (CHAR_COLS),
        .DOTS  (FONT_WIDTH),
        .POS_W (X_POS_W),
        .IDX_W (X_IDX_W)
    ) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (x_cmd),
        .size_eff (size_eff),
        .gap      (dot_gap_reg),
        .cgap     (col_gap_reg),
        .border   (border_reg),
        .stat     (x_stat),
        .pos      (x_pos),
        .idx      (x_idx)
    );

    dmrs_axis #(
        .CELLS (CHAR_ROWS),
        .DOTS  (FONT_HEIGHT),
        .POS_W (Y_POS_W),
        .IDX_W (Y_IDX_W)
    ) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (y_cmd),
        .size_eff (size_eff),
        .gap      (dot_gap_reg),
        .cgap     (row_gap_reg),
        .border   (border_reg),
        .stat     (y_stat),
        .pos      (y_pos),
        .idx      (y_idx)
    );

    // handshake and pipeline control
    logic clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    sync_t sync_reg, sync_next;
    logic [X_POS_W-1:0] tgt_x_reg, tgt_x_next;
    logic [Y_POS_W-1:0] tgt_y_reg, tgt_y_next;

    logic s1_valid_reg, s1_valid_next;
    logic s1_dot_reg;
    logic s1_le_reg;
    logic s1_fe_reg;
    logic rd_bit_reg;
    logic out_valid_reg, out_valid_next;
    logic [COLOUR_W-1:0] colour_reg;
    logic out_le_reg;
    logic out_fe_reg;

    logic s1_adv;
    logic in_acc;
    logic adv_acc;
    logic dot_acc;
    logic x_at_tgt;
    logic y_at_tgt;

    assign s1_adv    = !out_valid_reg || pix.ready;
    assign req.ready = !clr_active_reg && (sync_reg == SYNC_IDLE)
                    && (!s1_valid_reg || s1_adv);
    assign in_acc    = req.valid && req.ready;
    assign adv_acc   = in_acc && (req.kind == KIND_ADVANCE);
    assign dot_acc   = in_acc && (req.kind == KIND_DOT_WRITE);
    assign x_at_tgt  = (x_pos == tgt_x_reg);
    assign y_at_tgt  = (y_pos == tgt_y_reg);

    // store clearing pass
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_LAST)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // sync sequencer: next state
    always_comb
    begin
        sync_next = sync_reg;
        case (sync_reg)
            SYNC_IDLE:
            begin
                if (geo_write)
                begin
                    sync_next = SYNC_CLEAR;
                end
            end
            SYNC_CLEAR:
            begin
                if (!geo_write)
                begin
                    sync_next = SYNC_WALK;
                end
            end
            SYNC_WALK:
            begin
                if (geo_write)
                begin
                    sync_next = SYNC_CLEAR;
                end
                else if (x_at_tgt && y_at_tgt)
                begin
                    sync_next = SYNC_IDLE;
                end
            end
            default:
            begin
                sync_next = SYNC_CLEAR;
            end
        endcase
    end

    // sync sequencer and scan: axis commands
    always_comb
    begin
        x_cmd      = '0;
        y_cmd      = '0;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        case (sync_reg)
            SYNC_IDLE:
            begin
                if (geo_write)
                begin
                    tgt_x_next = x_pos;
                    tgt_y_next = y_pos;
                end
                if (adv_acc)
                begin
                    x_cmd.clear = x_stat.last;
                    x_cmd.step  = !x_stat.last;
                    y_cmd.clear = x_stat.last && y_stat.last;
                    y_cmd.step  = x_stat.last && !y_stat.last;
                end
            end
            SYNC_CLEAR:
            begin
                x_cmd.clear = 1'b1;
                y_cmd.clear = 1'b1;
            end
            SYNC_WALK:
            begin
                x_cmd.step = !x_at_tgt;
                y_cmd.step = !y_at_tgt;
            end
            default:
            begin
                x_cmd = '0;
                y_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            sync_reg       <= SYNC_CLEAR;
            tgt_x_reg      <= '0;
            tgt_y_reg      <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            sync_reg       <= sync_next;
            tgt_x_reg      <= tgt_x_next;
            tgt_y_reg      <= tgt_y_next;
        end
    end

    // dot store
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic                mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                wr_in_range;
    logic                store_mem [DOT_NUM];

    assign wr_in_range = (int'(req.dot_row) < DOT_ROWS) && (int'(req.dot_col) < DOT_COLS);
    assign mem_we      = clr_active_reg || (dot_acc && wr_in_range);
    assign mem_waddr   = clr_active_reg ? clr_addr_reg
                       : ADDR_W'(ADDR_W'(req.dot_row) * ADDR_W'(DOT_COLS)
                                 + ADDR_W'(req.dot_col));
    assign mem_wdata   = clr_active_reg ? 1'b0 : req.dot_value;
    assign mem_raddr   = ADDR_W'(ADDR_W'(y_idx) * ADDR_W'(DOT_COLS) + ADDR_W'(x_idx));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (adv_acc)
        begin
            rd_bit_reg <= store_mem[mem_raddr];
        end
    end

    // pixel pipeline
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (adv_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_acc)
        begin
            s1_dot_reg <= x_stat.on_dot && y_stat.on_dot;
            s1_le_reg  <= x_stat.last;
            s1_fe_reg  <= x_stat.last && y_stat.last;
        end
        if (s1_valid_reg && s1_adv)
        begin
            colour_reg <= !s1_dot_reg ? back_colour_reg
                        : (rd_bit_reg ? on_colour_reg : off_colour_reg);
            out_le_reg <= s1_le_reg;
            out_fe_reg <= s1_fe_reg;
        end
    end

    assign pix.valid     = out_valid_reg;
    assign pix.red       = colour_reg[3*CHAN_W-1:2*CHAN_W];
    assign pix.green     = colour_reg[2*CHAN_W-1:CHAN_W];
    assign pix.blue      = colour_reg[CHAN_W-1:0];
    assign pix.line_end  = out_le_reg;
    assign pix.frame_end = out_fe_reg;

endmodule

### rtl/dmrs_axis.sv
// One scan axis: position counter plus its split into border, cell, dot and
// phase within the dot pitch, all advanced together on each step command.
module dmrs_axis #(
    parameter int CELLS = 20,
    parameter int DOTS  = 5,
    parameter int POS_W = 12,
    parameter int IDX_W = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dmrs_pkg::axis_cmd_t              cmd,
    input  logic [dmrs_pkg::SIZE_W-1:0]      size_eff,
    input  logic [dmrs_pkg::GAP_W-1:0]       gap,
    input  logic [dmrs_pkg::GAP_W-1:0]       cgap,
    input  logic [dmrs_pkg::BORDER_W-1:0]    border,
    output dmrs_pkg::axis_stat_t             stat,
    output logic [POS_W-1:0]                 pos,
    output logic [IDX_W-1:0]                 idx
);
    import dmrs_pkg::*;

    localparam int DOT_W = (DOTS > 1) ? $clog2(DOTS) : 1;
    localparam logic [DOT_W-1:0] DOT_LAST = DOT_W'(DOTS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELLS * DOTS - 1);

    seg_t                seg_reg, seg_next;
    logic [BORDER_W-1:0] cnt_reg, cnt_next;
    logic [PITCH_W-1:0]  ph_reg, ph_next;
    logic [DOT_W-1:0]    dot_reg, dot_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic [PITCH_W-1:0]  pitch;
    logic [PITCH_W-1:0]  pitch_m1;
    logic [BORDER_W-1:0] cnt_inc;
    logic [POS_W-1:0]    extent;

    assign pitch    = PITCH_W'(size_eff) + PITCH_W'(gap);
    assign pitch_m1 = pitch - PITCH_W'(1);
    assign cnt_inc  = cnt_reg + BORDER_W'(1);
    assign extent   = POS_W'({border, 1'b0})
                    + POS_W'(cgap) * POS_W'(CELLS - 1)
                    + POS_W'(pitch) * POS_W'(CELLS * DOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= SEG_LEAD;
            cnt_reg <= '0;
            ph_reg  <= '0;
            dot_reg <= '0;
            idx_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            seg_reg <= seg_next;
            cnt_reg <= cnt_next;
            ph_reg  <= ph_next;
            dot_reg <= dot_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        seg_next = seg_reg;
        cnt_next = cnt_reg;
        ph_next  = ph_reg;
        dot_next = dot_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        if (cmd.clear)
        begin
            pos_next = '0;
            cnt_next = '0;
            ph_next  = '0;
            dot_next = '0;
            idx_next = '0;
            seg_next = (border == '0) ? SEG_DOTS : SEG_LEAD;
        end
        else if (cmd.step)
        begin
            pos_next = pos_reg + POS_W'(1);
            case (seg_reg)
                SEG_LEAD:
                begin
                    if (cnt_inc == border)
                    begin
                        seg_next = SEG_DOTS;
                        cnt_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                SEG_DOTS:
                begin
                    if (ph_reg == pitch_m1)
                    begin
                        ph_next = '0;
                        if (idx_reg == IDX_LAST)
                        begin
                            seg_next = SEG_TAIL;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                            if (dot_reg == DOT_LAST)
                            begin
                                dot_next = '0;
                                if (cgap != '0)
                                begin
                                    seg_next = SEG_CGAP;
                                    cnt_next = '0;
                                end
                            end
                            else
                            begin
                                dot_next = dot_reg + DOT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        ph_next = ph_reg + PITCH_W'(1);
                    end
                end
                SEG_CGAP:
                begin
                    if (cnt_inc == BORDER_W'(cgap))
                    begin
                        seg_next = SEG_DOTS;
                        cnt_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                SEG_TAIL:
                begin
                    seg_next = SEG_TAIL;
                end
                default:
                begin
                    seg_next = SEG_TAIL;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.on_dot = (seg_reg == SEG_DOTS) && (ph_reg < PITCH_W'(size_eff));
        stat.last   = ({1'b0, pos_reg} + (POS_W + 1)'(1)) >= {1'b0, extent};
        pos         = pos_reg;
        idx         = idx_reg;
    end

endmodule

### tb/sv/dot_matrix_raster_scanout_unit_tb.sv
module dot_matrix_raster_scanout_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmrs_pkg::*;

    localparam int CHAR_COLS   = 20;
    localparam int CHAR_ROWS   = 4;
    localparam int FONT_WIDTH  = 5;
    localparam int FONT_HEIGHT = 8;
    localparam int DOT_COLS    = CHAR_COLS * FONT_WIDTH;
    localparam int DOT_LINES   = CHAR_ROWS * FONT_HEIGHT;
    localparam int COL_TOP     = (1 << DOT_COL_W) - 1;
    localparam int ROW_TOP     = (1 << DOT_ROW_W) - 1;

    localparam real HALF_PERIOD   = 2.0;
    localparam int  RESET_CYCLES  = 10;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  TAIL_CYCLES   = 16;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  PRINT_CAP     = 200;
    localparam int  RUN_LIMIT_NS  = 4_000_000;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [DOT_ROW_W-1:0] dot_row;
        logic [DOT_COL_W-1:0] dot_col;
        logic                 dot_value;
    } req_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              line_end;
        logic              frame_end;
    } pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    dmrs_req_if req_bus ();
    dmrs_pix_if pix_bus ();

    dot_matrix_raster_scanout_unit #(
        .CHAR_COLS   (CHAR_COLS),
        .CHAR_ROWS   (CHAR_ROWS),
        .FONT_WIDTH  (FONT_WIDTH),
        .FONT_HEIGHT (FONT_HEIGHT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .req      (req_bus),
        .pix      (pix_bus)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // scan-out shadow state
    bit                  dot_plane [DOT_LINES][DOT_COLS];
    int unsigned         scan_col;
    int unsigned         scan_line;
    logic [SIZE_W-1:0]   m_dot_size;
    logic [GAP_W-1:0]    m_dot_gap;
    logic [GAP_W-1:0]    m_row_gap;
    logic [GAP_W-1:0]    m_col_gap;
    logic [BORDER_W-1:0] m_border;
    logic [COLOUR_W-1:0] m_on;
    logic [COLOUR_W-1:0] m_off;
    logic [COLOUR_W-1:0] m_back;

    req_item_t item_backlog [$];
    pixel_t    pixel_due [$];
    req_item_t held_item;

    int failures      = 0;
    int pixels_seen   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (failures < PRINT_CAP)
            $display("MISMATCH pixel %0d %s: got 0x%0h expected 0x%0h",
                     pixels_seen, what, got, want);
        failures++;
    endtask

    function automatic int unsigned dot_side();
        return (m_dot_size == 0) ? 1 : int'(m_dot_size);
    endfunction

    function automatic int unsigned axis_span(int unsigned cells, int unsigned dots,
                                              int unsigned cgap);
        int unsigned pitch;
        int unsigned brd;
        pitch = dot_side() + m_dot_gap;
        brd   = m_border;
        return 2 * brd + (cells - 1) * cgap + cells * dots * pitch;
    endfunction

    // false when the position lands on border or any gap
    function automatic bit axis_hit(int unsigned pos, int unsigned cells, int unsigned dots,
                                    int unsigned cgap, output int unsigned idx);
        int unsigned side;
        int unsigned pitch;
        int unsigned cell_span;
        int unsigned content;
        int unsigned p;
        int unsigned r;
        side      = dot_side();
        pitch     = side + m_dot_gap;
        cell_span = dots * pitch;
        content   = cells * cell_span + (cells - 1) * cgap;
        idx       = 0;
        if (pos < m_border)
            return 1'b0;
        p = pos - m_border;
        if (p >= content)
            return 1'b0;
        r = p % (cell_span + cgap);
        if (r >= cell_span || r % pitch >= side)
            return 1'b0;
        idx = (p / (cell_span + cgap)) * dots + r / pitch;
        return 1'b1;
    endfunction

    function automatic void render_item(req_item_t it);
        int unsigned         xs;
        int unsigned         ys;
        int unsigned         dx;
        int unsigned         dy;
        bit                  hit_x;
        bit                  hit_y;
        logic [COLOUR_W-1:0] colour;
        pixel_t              px;
        if (it.kind == KIND_DOT_WRITE)
        begin
            if (it.dot_row < DOT_LINES && it.dot_col < DOT_COLS)
                dot_plane[it.dot_row][it.dot_col] = it.dot_value;
            return;
        end
        xs     = axis_span(CHAR_COLS, FONT_WIDTH, m_col_gap);
        ys     = axis_span(CHAR_ROWS, FONT_HEIGHT, m_row_gap);
        colour = m_back;
        // position past a shrunken frame stays background
        if (scan_col < xs && scan_line < ys)
        begin
            hit_x = axis_hit(scan_col, CHAR_COLS, FONT_WIDTH, m_col_gap, dx);
            hit_y = axis_hit(scan_line, CHAR_ROWS, FONT_HEIGHT, m_row_gap, dy);
            if (hit_x && hit_y && dx < DOT_COLS && dy < DOT_LINES)
                colour = dot_plane[dy][dx] ? m_on : m_off;
        end
        px.red       = colour[23:16];
        px.green     = colour[15:8];
        px.blue      = colour[7:0];
        px.line_end  = (scan_col >= xs - 1);
        px.frame_end = px.line_end && (scan_line >= ys - 1);
        pixel_due.push_back(px);
        if (px.frame_end)
        begin
            scan_col  = 0;
            scan_line = 0;
        end
        else if (px.line_end)
        begin
            scan_col = 0;
            scan_line++;
        end
        else
            scan_col++;
    endfunction

    task automatic check_pixel();
        pixel_t want;
        pixels_seen++;
        if (pixel_due.size() == 0)
        begin
            report_mismatch("pixel with none expected", 1, 0);
            return;
        end
        want = pixel_due.pop_front();
        if (pix_bus.red != want.red)
            report_mismatch("red", pix_bus.red, want.red);
        if (pix_bus.green != want.green)
            report_mismatch("green", pix_bus.green, want.green);
        if (pix_bus.blue != want.blue)
            report_mismatch("blue", pix_bus.blue, want.blue);
        if (pix_bus.line_end != want.line_end)
            report_mismatch("line_end", pix_bus.line_end, want.line_end);
        if (pix_bus.frame_end != want.frame_end)
            report_mismatch("frame_end", pix_bus.frame_end, want.frame_end);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid     <= 1'b0;
            req_bus.kind      <= KIND_DOT_WRITE;
            req_bus.dot_row   <= '0;
            req_bus.dot_col   <= '0;
            req_bus.dot_value <= 1'b0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                render_item(held_item);
            if (!req_bus.valid || req_bus.ready)
            begin
                if (item_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    held_item          = item_backlog.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.kind      <= held_item.kind;
                    req_bus.dot_row   <= held_item.dot_row;
                    req_bus.dot_col   <= held_item.dot_col;
                    req_bus.dot_value <= held_item.dot_value;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // pixel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_bus.ready <= 1'b0;
            hold_left      = 0;
        end
        else
        begin
            if (pix_bus.valid && pix_bus.ready)
                check_pixel();
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_bus.ready <= 1'b0;
            end
            else
                pix_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic push_item(logic [KIND_W-1:0] kind, int unsigned row,
                             int unsigned col, int unsigned lit);
        req_item_t it;
        it.kind      = kind;
        it.dot_row   = DOT_ROW_W'(row);
        it.dot_col   = DOT_COL_W'(col);
        it.dot_value = 1'(lit);
        item_backlog.push_back(it);
    endtask

    task automatic queue_random(int count, int write_pct, int row_hi, int col_hi);
        req_item_t it;
        repeat (count)
        begin
            it.kind      = KIND_ADVANCE;
            it.dot_row   = DOT_ROW_W'($urandom_range(0, ROW_TOP));
            it.dot_col   = DOT_COL_W'($urandom_range(0, COL_TOP));
            it.dot_value = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < write_pct)
            begin
                it.kind      = KIND_DOT_WRITE;
                it.dot_row   = DOT_ROW_W'($urandom_range(0, row_hi));
                it.dot_col   = DOT_COL_W'(($urandom_range(0, 9) == 0)
                                          ? $urandom_range(DOT_COLS, COL_TOP)
                                          : $urandom_range(0, col_hi));
                it.dot_value = ($urandom_range(0, 3) != 0);
            end
            item_backlog.push_back(it);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || req_bus.valid || pixel_due.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        // a write can still be in flight; a geometry write also rebuilds with ready low
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_DOT_SIZE:    m_dot_size = val[SIZE_W-1:0];
            REG_DOT_GAP:     m_dot_gap  = val[GAP_W-1:0];
            REG_ROW_GAP:     m_row_gap  = val[GAP_W-1:0];
            REG_COL_GAP:     m_col_gap  = val[GAP_W-1:0];
            REG_BORDER:      m_border   = val[BORDER_W-1:0];
            REG_ON_COLOUR:   m_on       = val[COLOUR_W-1:0];
            REG_OFF_COLOUR:  m_off      = val[COLOUR_W-1:0];
            REG_BACK_COLOUR: m_back     = val[COLOUR_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic apply_setup(int unsigned size, int unsigned dgap,
                               int unsigned rgap, int unsigned cgap,
                               int unsigned brd, int unsigned on_c,
                               int unsigned off_c, int unsigned back_c);
        write_reg(REG_DOT_SIZE, CFG_DATA_W'(size));
        write_reg(REG_DOT_GAP, CFG_DATA_W'(dgap));
        write_reg(REG_ROW_GAP, CFG_DATA_W'(rgap));
        write_reg(REG_COL_GAP, CFG_DATA_W'(cgap));
        write_reg(REG_BORDER, CFG_DATA_W'(brd));
        write_reg(REG_ON_COLOUR, CFG_DATA_W'(on_c));
        write_reg(REG_OFF_COLOUR, CFG_DATA_W'(off_c));
        write_reg(REG_BACK_COLOUR, CFG_DATA_W'(back_c));
    endtask

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("dot_matrix_raster_scanout_unit verification failed");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = '0;
        wr_data           = '0;
        req_bus.valid     = 1'b0;
        req_bus.kind      = KIND_DOT_WRITE;
        req_bus.dot_row   = '0;
        req_bus.dot_col   = '0;
        req_bus.dot_value = 1'b0;
        pix_bus.ready     = 1'b0;

        scan_col   = 0;
        scan_line  = 0;
        m_dot_size = DOT_SIZE_RST;
        m_dot_gap  = DOT_GAP_RST;
        m_row_gap  = ROW_GAP_RST;
        m_col_gap  = COL_GAP_RST;
        m_border   = BORDER_RST;
        m_on       = ON_COLOUR_RST;
        m_off      = OFF_COLOUR_RST;
        m_back     = BACK_COLOUR_RST;

        src_idle_pct  = 36;
        sink_idle_pct = 55;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // corner dots, writes off the store edge, an overwrite, then scan a few pixels
        push_item(KIND_DOT_WRITE, 0, 0, 1);
        push_item(KIND_DOT_WRITE, 0, DOT_COLS - 1, 1);
        push_item(KIND_DOT_WRITE, DOT_LINES - 1, 0, 1);
        push_item(KIND_DOT_WRITE, DOT_LINES - 1, DOT_COLS - 1, 1);
        push_item(KIND_DOT_WRITE, 0, DOT_COLS, 1);
        push_item(KIND_DOT_WRITE, ROW_TOP, COL_TOP, 1);
        push_item(KIND_DOT_WRITE, 16, 64, 1);
        push_item(KIND_DOT_WRITE, 0, 1, 1);
        push_item(KIND_DOT_WRITE, 0, 1, 0);
        push_item(KIND_DOT_WRITE, 0, 2, 1);
        repeat (12)
            push_item(KIND_ADVANCE, $urandom_range(0, ROW_TOP), $urandom_range(0, COL_TOP),
                      $urandom_range(0, 1));
        wait_drained();

        apply_setup(2, 1, 2, 2, 0, $urandom, $urandom, $urandom);
        queue_random(200, 40, 1, DOT_COLS - 1);
        wait_drained();

        src_idle_pct  = 55;
        sink_idle_pct = 36;
        apply_setup(15, 15, 15, 15, 0, 24'hffffff, 24'h000000, $urandom);
        queue_random(150, 30, 1, 20);
        wait_drained();

        // smallest frame with scan left far past its right edge
        apply_setup(0, 0, 0, 0, 0, 24'h000000, $urandom, 24'hffffff);
        queue_random(300, 20, DOT_LINES - 1, DOT_COLS - 1);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        apply_setup(1, 0, 0, 0, 63, $urandom, $urandom, $urandom);
        queue_random(150, 20, DOT_LINES - 1, DOT_COLS - 1);
        wait_drained();

        // upper data bits carry junk on the narrow registers
        apply_setup($urandom, $urandom, $urandom, $urandom, $urandom & 24'hffffc7,
                    $urandom, $urandom, $urandom);
        queue_random(115, 35, DOT_LINES - 1, DOT_COLS - 1);
        hold_asks++;
        wait_drained();
        queue_random(115, 35, DOT_LINES - 1, DOT_COLS - 1);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pixel_due.size() != 0)
            report_mismatch("pixels never delivered", 0, pixel_due.size());

        if (failures == 0)
            $display("dot_matrix_raster_scanout_unit verification clean");
        else
            $display("dot_matrix_raster_scanout_unit verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/dmrs_pkg.sv
rtl/dmrs_req_if.sv
rtl/dmrs_pix_if.sv
rtl/dmrs_axis.sv
rtl/dot_matrix_raster_scanout_unit.sv
tb/sv/dot_matrix_raster_scanout_unit_tb.sv
